// ===== hdl/rsa_pkg.sv =====
// Shared constants and command/status types for the rational sum accumulator.
// No dependencies.
`timescale 1ns / 1ps
package rsa_pkg;
    localparam int IN_WIDTH_DEF  = 32;
    localparam int SUM_WIDTH_DEF = 64;
    localparam int OUT_WIDTH     = 63;

    typedef enum logic [2:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_MUL,
        CMD_COMBINE,
        CMD_GCD_STEP,
        CMD_DIV_START,
        CMD_DIV_STEP,
        CMD_COMMIT
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t op;
        logic    last;
    } rsa_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic gcd_done;
        logic div_done;
        logic bad_den;
    } rsa_status_t;
endpackage

// ===== hdl/rsa_datapath.sv =====
// Datapath: cross-multiply, add, binary GCD, restoring divides, mixed-number split.
// Depends on rsa_pkg.
`timescale 1ns / 1ps
module rsa_datapath
    import rsa_pkg::*;
#(
    parameter int IN_WIDTH  = IN_WIDTH_DEF,
    parameter int SUM_WIDTH = SUM_WIDTH_DEF
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  rsa_cmd_t                    cmd,
    input  logic signed [IN_WIDTH-1:0]  numerator,
    input  logic [IN_WIDTH-2:0]         denominator,
    output rsa_status_t                 status,
    output logic                        negative,
    output logic [OUT_WIDTH-1:0]        whole_part,
    output logic [OUT_WIDTH-1:0]        remainder,
    output logic [OUT_WIDTH-1:0]        sum_denominator,
    output logic                        overflow
);
    localparam int SW  = SUM_WIDTH;
    localparam int WW  = 2 * SUM_WIDTH;
    localparam int CW  = $clog2(WW + 1);
    localparam int HW  = SW / 2;

    logic [SW-1:0] acc_num_reg, acc_num_next;
    logic [SW-1:0] acc_den_reg, acc_den_next;
    logic          ovf_reg, ovf_next;

    logic          a_neg_reg;
    logic [SW-1:0] a_mag_reg, b_reg, s_mag_reg;
    logic          s_neg_reg;

    // multiplier: one half-by-half partial product per cycle
    logic [1:0]    mph_reg;
    logic [WW-1:0] t1_reg, t2_reg, nd_reg;
    logic [WW-1:0] nm_reg;
    logic          n_neg_reg;

    logic [WW-1:0] u_reg, v_reg;
    logic [CW-1:0] shift_reg;
    logic [1:0]    gph_reg;

    // divider: phase 0 numerator, 1 denominator, 2 mixed-number split
    logic [1:0]    dph_reg;
    logic [WW-1:0] dn_reg, dr_reg, dq_reg, dd_reg;
    logic [CW-1:0] dcnt_reg;
    logic [WW-1:0] qn_reg, qd_reg;
    logic          mul_done_reg, gcd_done_reg, div_done_reg;

    logic [WW-1:0]   rsh;
    logic [WW:0]     rdiff;
    logic [2*HW-1:0] pp;
    logic [SW-1:0]   limit;
    logic [SW-1:0]   cur_mag;
    logic [SW-1:0]   new_mag;

    assign limit   = {1'b0, {(SW-1){1'b1}}};
    assign rsh     = {dr_reg[WW-2:0], dn_reg[WW-1]};
    assign rdiff   = {1'b0, rsh} - {1'b0, dd_reg};
    assign cur_mag = acc_num_reg[SW-1] ? (~acc_num_reg + 1'b1) : acc_num_reg;
    assign new_mag = acc_num_next[SW-1] ? (~acc_num_next + 1'b1) : acc_num_next;

    always_comb
    begin
        logic [SW-1:0] mx, my;
        logic [HW-1:0] mh, ml;
        mx = s_mag_reg;
        my = b_reg;
        case (mph_reg)
            2'd0: begin mx = s_mag_reg; my = b_reg; end
            2'd1: begin mx = a_mag_reg; my = acc_den_reg; end
            default: begin mx = acc_den_reg; my = b_reg; end
        endcase
        mh = gph_reg[0] ? mx[SW-1:HW] : mx[HW-1:0];
        ml = gph_reg[1] ? my[SW-1:HW] : my[HW-1:0];
        pp = mh * ml;
    end

    assign status.mul_done = mul_done_reg;
    assign status.gcd_done = gcd_done_reg;
    assign status.div_done = div_done_reg;
    assign status.bad_den  = (b_reg == '0);

    always_comb
    begin
        acc_num_next = acc_num_reg;
        acc_den_next = acc_den_reg;
        ovf_next     = ovf_reg;
        if (cmd.op == CMD_COMMIT) begin
            if (b_reg == '0 || qn_reg[WW-1:SW] != '0 || qd_reg[WW-1:SW] != '0
                || qn_reg[SW-1:0] > limit || qd_reg[SW-1:0] > limit) begin
                ovf_next = 1'b1;
            end else begin
                acc_num_next = (n_neg_reg && qn_reg[SW-1:0] != '0)
                             ? (~qn_reg[SW-1:0] + 1'b1) : qn_reg[SW-1:0];
                acc_den_next = qd_reg[SW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            acc_num_reg  <= '0;
            acc_den_reg  <= SW'(1);
            ovf_reg      <= 1'b0;
            mul_done_reg <= 1'b0;
            gcd_done_reg <= 1'b0;
            div_done_reg <= 1'b0;
            mph_reg      <= '0;
            gph_reg      <= '0;
            dph_reg      <= '0;
        end else if (cmd.op == CMD_COMMIT && cmd.last) begin
            acc_num_reg  <= '0;
            acc_den_reg  <= SW'(1);
            ovf_reg      <= 1'b0;
        end else begin
            acc_num_reg  <= acc_num_next;
            acc_den_reg  <= acc_den_next;
            ovf_reg      <= ovf_next;
        end

        if (rst_n) begin
            case (cmd.op)
                CMD_LOAD: begin
                    a_neg_reg    <= numerator[IN_WIDTH-1] && (numerator[IN_WIDTH-2:0] != '0
                                    || 1'b1) && (numerator != '0);
                    a_mag_reg    <= numerator[IN_WIDTH-1]
                                  ? SW'(IN_WIDTH'(~numerator + 1'b1))
                                  : SW'(unsigned'(numerator));
                    b_reg        <= SW'(denominator);
                    s_neg_reg    <= acc_num_reg[SW-1];
                    s_mag_reg    <= cur_mag;
                    mph_reg      <= '0;
                    gph_reg      <= '0;
                    t1_reg       <= '0;
                    t2_reg       <= '0;
                    nd_reg       <= '0;
                    mul_done_reg <= 1'b0;
                    gcd_done_reg <= 1'b0;
                    div_done_reg <= 1'b0;
                    negative     <= 1'b0;
                end
                CMD_MUL: begin
                    logic [WW-1:0] add;
                    case (gph_reg)
                        2'd0:    add = WW'(pp);
                        2'd3:    add = WW'(pp) << (2 * HW);
                        default: add = WW'(pp) << HW;
                    endcase
                    case (mph_reg)
                        2'd0:    t1_reg <= t1_reg + add;
                        2'd1:    t2_reg <= t2_reg + add;
                        default: nd_reg <= nd_reg + add;
                    endcase
                    if (gph_reg == 2'd3) begin
                        gph_reg <= '0;
                        if (mph_reg == 2'd2) mul_done_reg <= 1'b1;
                        else mph_reg <= mph_reg + 2'd1;
                    end else begin
                        gph_reg <= gph_reg + 2'd1;
                    end
                end
                CMD_COMBINE: begin
                    logic [WW-1:0] m;
                    logic          ng;
                    if (s_neg_reg == a_neg_reg) begin
                        m = t1_reg + t2_reg; ng = s_neg_reg;
                    end else if (t1_reg >= t2_reg) begin
                        m = t1_reg - t2_reg; ng = s_neg_reg;
                    end else begin
                        m = t2_reg - t1_reg; ng = a_neg_reg;
                    end
                    nm_reg    <= m;
                    n_neg_reg <= ng;
                    u_reg     <= m;
                    v_reg     <= nd_reg;
                    shift_reg <= '0;
                    gph_reg   <= (m == '0) ? 2'd3 : 2'd0;
                end
                CMD_GCD_STEP: begin
                    case (gph_reg)
                        2'd0: begin
                            if ((u_reg[0] | v_reg[0]) == 1'b0) begin
                                u_reg <= u_reg >> 1; v_reg <= v_reg >> 1;
                                shift_reg <= shift_reg + 1'b1;
                            end else gph_reg <= 2'd1;
                        end
                        2'd1: begin
                            if (!u_reg[0]) u_reg <= u_reg >> 1;
                            else gph_reg <= 2'd2;
                        end
                        2'd2: begin
                            if (!v_reg[0]) v_reg <= v_reg >> 1;
                            else if (u_reg > v_reg) begin
                                u_reg <= v_reg; v_reg <= u_reg - v_reg;
                                if (u_reg == v_reg) gph_reg <= 2'd3;
                            end else begin
                                v_reg <= v_reg - u_reg;
                                if (u_reg == v_reg) gph_reg <= 2'd3;
                            end
                        end
                        default: begin
                            if (nm_reg == '0) begin
                                u_reg <= v_reg; gcd_done_reg <= 1'b1;
                            end else if (shift_reg != '0) begin
                                u_reg <= u_reg << 1;
                                shift_reg <= shift_reg - 1'b1;
                            end else gcd_done_reg <= 1'b1;
                        end
                    endcase
                end
                CMD_DIV_START: begin
                    dph_reg  <= '0;
                    dn_reg   <= nm_reg;
                    dd_reg   <= u_reg;
                    dr_reg   <= '0;
                    dq_reg   <= '0;
                    dcnt_reg <= CW'(WW);
                    div_done_reg <= 1'b0;
                end
                CMD_DIV_STEP: begin
                    if (dcnt_reg != '0) begin
                        dn_reg   <= dn_reg << 1;
                        dcnt_reg <= dcnt_reg - 1'b1;
                        if (!rdiff[WW]) begin
                            dr_reg <= rdiff[WW-1:0];
                            dq_reg <= {dq_reg[WW-2:0], 1'b1};
                        end else begin
                            dr_reg <= rsh;
                            dq_reg <= {dq_reg[WW-2:0], 1'b0};
                        end
                    end else begin
                        dr_reg   <= '0;
                        dq_reg   <= '0;
                        dcnt_reg <= CW'(WW);
                        case (dph_reg)
                            2'd0: begin
                                qn_reg <= dq_reg; dn_reg <= nd_reg; dph_reg <= 2'd1;
                            end
                            2'd1: begin
                                qd_reg <= dq_reg; div_done_reg <= 1'b1;
                            end
                            default: begin
                                whole_part      <= dq_reg[OUT_WIDTH-1:0];
                                remainder       <= dr_reg[OUT_WIDTH-1:0];
                                div_done_reg    <= 1'b1;
                            end
                        endcase
                    end
                end
                CMD_COMMIT: begin
                    // split the new sum into whole and remainder
                    dph_reg  <= 2'd2;
                    dn_reg   <= WW'(new_mag);
                    dd_reg   <= WW'(acc_den_next);
                    dr_reg   <= '0;
                    dq_reg   <= '0;
                    dcnt_reg <= CW'(WW);
                    div_done_reg    <= 1'b0;
                    negative        <= acc_num_next[SW-1];
                    sum_denominator <= OUT_WIDTH'(acc_den_next);
                    overflow        <= ovf_next;
                end
                default: ;
            endcase
        end
    end
endmodule

// ===== hdl/rsa_ctrl.sv =====
// Controller state machine: sequences the datapath and runs the handshakes.
// Depends on rsa_pkg.
`timescale 1ns / 1ps
module rsa_ctrl
    import rsa_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    output logic        out_valid,
    input  logic        out_stall,
    input  logic        last,
    output logic        final_res,
    input  rsa_status_t status,
    output rsa_cmd_t    cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_MUL, S_COMB, S_GCD, S_DIVN, S_COMMIT, S_SPLIT
    } state_t;

    state_t state_reg;
    logic   last_reg;
    logic   out_valid_reg;
    logic   start;

    assign in_stall  = (state_reg != S_IDLE) || (out_valid_reg && out_stall);
    assign start     = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign final_res = last_reg;

    always_comb
    begin
        cmd.last = last_reg;
        case (state_reg)
            S_IDLE:   cmd.op = start ? CMD_LOAD : CMD_NONE;
            S_MUL:    cmd.op = status.mul_done ? CMD_NONE : CMD_MUL;
            S_COMB:   cmd.op = CMD_COMBINE;
            S_GCD:    cmd.op = status.gcd_done ? CMD_DIV_START : CMD_GCD_STEP;
            S_DIVN:   cmd.op = status.div_done ? CMD_NONE : CMD_DIV_STEP;
            S_COMMIT: cmd.op = CMD_COMMIT;
            S_SPLIT:  cmd.op = status.div_done ? CMD_NONE : CMD_DIV_STEP;
            default:  cmd.op = CMD_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_IDLE;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (out_valid_reg && !out_stall) out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE: if (start) begin
                    last_reg  <= last;
                    state_reg <= S_MUL;
                end
                S_MUL:    if (status.mul_done) state_reg <= S_COMB;
                S_COMB:   state_reg <= status.bad_den ? S_COMMIT : S_GCD;
                S_GCD:    if (status.gcd_done) state_reg <= S_DIVN;
                S_DIVN:   if (status.div_done) state_reg <= S_COMMIT;
                S_COMMIT: state_reg <= S_SPLIT;
                S_SPLIT:  if (status.div_done) begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:  state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== hdl/rational_sum_accumulator_core.sv =====
// Rational sum accumulator: adds fractions, reduces by GCD, reports a mixed number.
// A zero denominator skips the GCD and the reducing divides; only the mixed-number split runs.
// One transaction at a time; the next can be accepted in the same cycle as the result leaves.
// Reset (rst_n, asynchronous, active low): sum 0/1, overflow clear, no result pending.
// Depends on rsa_pkg, rsa_ctrl, rsa_datapath.
`timescale 1ns / 1ps
module rational_sum_accumulator_core
    import rsa_pkg::*;
#(
    parameter int IN_WIDTH  = IN_WIDTH_DEF,
    parameter int SUM_WIDTH = SUM_WIDTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic signed [IN_WIDTH-1:0] numerator,
    input  logic [IN_WIDTH-2:0]        denominator,
    input  logic                       last,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       negative,
    output logic [OUT_WIDTH-1:0]       whole_part,
    output logic [OUT_WIDTH-1:0]       remainder,
    output logic [OUT_WIDTH-1:0]       sum_denominator,
    output logic                       overflow,
    output logic                       final_res
);
    rsa_cmd_t    cmd;
    rsa_status_t status;

    rsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .last      (last),
        .final_res (final_res),
        .status    (status),
        .cmd       (cmd)
    );

    rsa_datapath #(
        .IN_WIDTH  (IN_WIDTH),
        .SUM_WIDTH (SUM_WIDTH)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .numerator       (numerator),
        .denominator     (denominator),
        .status          (status),
        .negative        (negative),
        .whole_part      (whole_part),
        .remainder       (remainder),
        .sum_denominator (sum_denominator),
        .overflow        (overflow)
    );
endmodule

// ===== tb/rsa_checker.sv =====
// Checker for the rational sum accumulator: watches both channels, predicts each sum and compares.
// Depends on rsa_pkg; instantiated beside the block by tb_top.
`timescale 1ns / 1ps
module rsa_checker
    import rsa_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    input  logic                        in_stall,
    input  logic signed [IN_WIDTH_DEF-1:0] numerator,
    input  logic [IN_WIDTH_DEF-2:0]     denominator,
    input  logic                        last,
    input  logic                        out_valid,
    input  logic                        out_stall,
    input  logic                        negative,
    input  logic [OUT_WIDTH-1:0]        whole_part,
    input  logic [OUT_WIDTH-1:0]        remainder,
    input  logic [OUT_WIDTH-1:0]        sum_denominator,
    input  logic                        overflow,
    input  logic                        final_res,
    output int                          fail_count,
    output int                          pending
);

    typedef struct packed {
        logic                 negative;
        logic [OUT_WIDTH-1:0] whole_part;
        logic [OUT_WIDTH-1:0] remainder;
        logic [OUT_WIDTH-1:0] sum_denominator;
        logic                 overflow;
        logic                 final_res;
    } mixed_sum_t;

    logic [63:0] sum_num;
    logic [63:0] sum_den;
    logic        sum_ovf;
    mixed_sum_t  sums_due[$];

    function automatic logic [127:0] euclid(input logic [127:0] a, input logic [127:0] b);
        logic [127:0] t;
        while (b != 0)
        begin
            t = a % b;
            a = b;
            b = t;
        end
        return a;
    endfunction

    function automatic mixed_sum_t add_fraction(input logic [IN_WIDTH_DEF-1:0] n,
                                                input logic [IN_WIDTH_DEF-2:0] d,
                                                input logic lst);
        mixed_sum_t   r;
        logic         a_neg, s_neg, n_neg;
        logic [63:0]  a_mag, s_mag, mag;
        logic [127:0] t1, t2, nd, nm, g;
        a_neg = n[IN_WIDTH_DEF-1];
        a_mag = a_neg ? 64'(-n) & 64'hFFFF_FFFF : 64'(n);
        if (a_mag == 0)
            a_neg = 1'b0;
        s_neg = sum_num[63];
        s_mag = s_neg ? -sum_num : sum_num;
        if (d == 0)
            sum_ovf = 1'b1;
        else
        begin
            t1 = 128'(s_mag) * 128'(d);
            t2 = 128'(a_mag) * 128'(sum_den);
            nd = 128'(sum_den) * 128'(d);
            if (s_neg == a_neg)
            begin
                nm = t1 + t2;
                n_neg = s_neg;
            end
            else if (t1 >= t2)
            begin
                nm = t1 - t2;
                n_neg = s_neg;
            end
            else
            begin
                nm = t2 - t1;
                n_neg = a_neg;
            end
            g = euclid(nm, nd);
            nm = nm / g;
            nd = nd / g;
            if (nm > 128'h7FFF_FFFF_FFFF_FFFF || nd > 128'h7FFF_FFFF_FFFF_FFFF)
                sum_ovf = 1'b1;
            else
            begin
                if (nm == 0)
                    n_neg = 1'b0;
                sum_num = n_neg ? -nm[63:0] : nm[63:0];
                sum_den = nd[63:0];
            end
        end
        s_neg = sum_num[63];
        mag = s_neg ? -sum_num : sum_num;
        r.negative = s_neg;
        r.whole_part = OUT_WIDTH'(mag / sum_den);
        r.remainder = OUT_WIDTH'(mag % sum_den);
        r.sum_denominator = OUT_WIDTH'(sum_den);
        r.overflow = sum_ovf;
        r.final_res = lst;
        if (lst)
        begin
            sum_num = 64'd0;
            sum_den = 64'd1;
            sum_ovf = 1'b0;
        end
        return r;
    endfunction

    assign pending = sums_due.size();

    always @(posedge clk or negedge rst_n)
    begin
        mixed_sum_t seen, want;
        if (!rst_n)
        begin
            sum_num = 64'd0;
            sum_den = 64'd1;
            sum_ovf = 1'b0;
            fail_count = 0;
            sums_due.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                seen = '{negative, whole_part, remainder, sum_denominator, overflow, final_res};
                if (sums_due.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("unexpected transaction: %p", seen);
                end
                else
                begin
                    want = sums_due.pop_front();
                    if (seen !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected %p, actual %p", want, seen);
                    end
                end
            end
            if (in_valid && !in_stall)
                sums_due.push_back(add_fraction(numerator, denominator, last));
        end
    end

endmodule

// ===== tb/tb_top.sv =====
// Top of the rational sum accumulator testbench: clock, reset, stimulus, idling and verdict.
// Depends on rsa_pkg, rational_sum_accumulator_core and rsa_checker.
`timescale 1ns / 1ps
module tb_top;
    import rsa_pkg::*;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic signed [IN_WIDTH_DEF-1:0] numerator = '0;
    logic [IN_WIDTH_DEF-2:0]       denominator = (IN_WIDTH_DEF-1)'(1);
    logic                          last = 1'b0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic                          negative;
    logic [OUT_WIDTH-1:0]          whole_part;
    logic [OUT_WIDTH-1:0]          remainder;
    logic [OUT_WIDTH-1:0]          sum_denominator;
    logic                          overflow;
    logic                          final_res;
    int                            fail_count;
    int                            pending;
    logic                          idling = 1'b1;
    logic                          hold_request = 1'b0;
    int                            quiet_cycles = 0;

    always #5 clk = ~clk;

    rational_sum_accumulator_core u_dut (.*);

    rsa_checker u_checker (.*);

    // Receiver: random stall bursts, one long hold-off on request.
    always @(posedge clk)
    begin
        static int burst = 0;
        static int hold = 0;
        if (hold_request && hold == 0)
            hold = 3000;
        if (hold > 0)
        begin
            hold--;
            out_stall <= (hold != 0);
            if (hold == 0)
                hold_request <= 1'b0;
        end
        else if (burst > 0)
        begin
            burst--;
            out_stall <= 1'b1;
        end
        else if (idling && $urandom_range(0, 5) == 0)
        begin
            burst = $urandom_range(1, 18) - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= 1'b0;
    end

    // Watchdog on cycles without any accepted transaction.
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            quiet_cycles <= 0;
        else if (quiet_cycles >= 20000)
        begin
            $display("simulation failed");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic send_fraction(input logic [IN_WIDTH_DEF-1:0] n,
                                 input logic [IN_WIDTH_DEF-2:0] d, input logic lst);
        if (idling && $urandom_range(0, 7) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        in_valid <= 1'b1;
        numerator <= n;
        denominator <= d;
        last <= lst;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    function automatic logic [IN_WIDTH_DEF-1:0] pick_numerator();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 5)
            return IN_WIDTH_DEF'($signed($urandom_range(0, 40)) - 20);
        else if (sel < 9)
            return $urandom;
        else
            return sel[0] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endfunction

    function automatic logic [IN_WIDTH_DEF-2:0] pick_denominator();
        int sel;
        sel = $urandom_range(0, 49);
        if (sel < 30)
            return (IN_WIDTH_DEF-1)'($urandom_range(1, 12));
        else if (sel < 45)
            return (IN_WIDTH_DEF-1)'($urandom_range(1, 1000));
        else if (sel < 49)
            return (IN_WIDTH_DEF-1)'($urandom);
        else
            return '0;
    endfunction

    initial
    begin
        int count;
        int set_len;
        bit hold_sent;
        bit drained;
        hold_sent = 1'b0;
        drained = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_fraction(32'h0000_0000, 31'd1, 1'b0);
        send_fraction(32'h7FFF_FFFF, 31'd1, 1'b0);
        send_fraction(32'h8000_0000, 31'd1, 1'b0);
        send_fraction(32'hFFFF_FFFF, 31'h7FFF_FFFF, 1'b1);
        send_fraction(32'd1, 31'd3, 1'b0);
        send_fraction(32'hFFFF_FFFF, 31'd3, 1'b0);
        send_fraction(32'd5, 31'd0, 1'b0);
        send_fraction(32'd7, 31'd2, 1'b1);
        send_fraction(32'd1, 31'h7FFF_FFFF, 1'b0);
        send_fraction(32'd1, 31'h7FFF_FFED, 1'b0);
        send_fraction(32'd1, 31'h7FFF_FFE1, 1'b0);
        send_fraction(32'd1, 31'h7FFF_FF8B, 1'b0);
        send_fraction(32'h8000_0000, 31'd1, 1'b1);
        send_fraction(32'h7FFF_FFFF, 31'd2, 1'b0);
        send_fraction(32'h7FFF_FFFF, 31'd2, 1'b0);
        send_fraction(32'hFFFF_FFF9, 31'd4, 1'b0);
        send_fraction(32'd7, 31'd4, 1'b1);
        send_fraction(32'hAAAA_AAAA, 31'h5555_5555, 1'b0);
        send_fraction(32'h5555_5555, 31'h2AAA_AAAA, 1'b1);

        count = 0;
        while (count < 950)
        begin
            if (!hold_sent && count >= 300)
            begin
                hold_request <= 1'b1;
                hold_sent = 1'b1;
            end
            if (!drained && count >= 500)
            begin
                in_valid <= 1'b0;
                wait (pending == 0);
                @(posedge clk);
                drained = 1'b1;
            end
            if (count >= 850)
                idling <= 1'b0;
            set_len = $urandom_range(1, 10);
            for (int i = 0; i < set_len; i++)
                send_fraction(pick_numerator(), pick_denominator(), i == set_len - 1);
            count += set_len;
        end
        in_valid <= 1'b0;
        wait (pending == 0);
        repeat (700) @(posedge clk);
        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
